FILE: sv/rte_pkg.sv
// Shared types and function codes for the R-type execute unit.
// No dependencies; every other file of the unit imports this package.
package rte_pkg;

  // Function codes of the supported R-type instructions
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_NAND  = 6'h28;
  localparam logic [5:0] FN_SLT   = 6'h2a;

  // Action codes
  localparam logic ACT_EXEC = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam logic [4:0] REG_ZERO = 5'd0;

  // One instruction item
  typedef struct packed {
    logic        action;
    logic [5:0]  function_code;
    logic [4:0]  source_reg;
    logic [4:0]  target_reg;
    logic [4:0]  dest_reg;
    logic [4:0]  shift_amount;
    logic [31:0] load_value;
  } rte_cmd_t;

  // One result item
  typedef struct packed {
    logic        write_enable;
    logic [4:0]  write_reg;
    logic [31:0] write_value;
    logic        jump_taken;
    logic [29:0] jump_target;
    logic        write_zero_error;
    logic        overflow_error;
    logic        hilo_overwrite_error;
    logic        unknown_function;
  } rte_res_t;

  // Register file write port
  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } rte_wr_t;

  // Hi/Lo update requested by the ALU
  typedef struct packed {
    logic        mult_en;
    logic        clear_unread;
    logic [31:0] hi;
    logic [31:0] lo;
  } rte_hilo_t;

endpackage

FILE: sv/rte_regfile.sv
// 32 x 32 register file in a synchronous two-read, one-write memory.
// Valid bits give the all-zero reset; a bypass register covers the write
// that lands on the same edge as a read. Depends on rte_pkg.
module rte_regfile import rte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [4:0]  rs_addr,
  input  logic [4:0]  rt_addr,
  input  rte_wr_t     wr,
  output logic [31:0] rs_data,
  output logic [31:0] rt_data
);

  logic [31:0] mem [32];
  logic [31:0] valid;
  logic [31:0] rs_q;
  logic [31:0] rt_q;
  logic        rs_vq;
  logic        rt_vq;
  logic [4:0]  rs_aq;
  logic [4:0]  rt_aq;
  logic        fwd_en;
  logic [4:0]  fwd_addr;
  logic [31:0] fwd_data;

  // Write port and registered read ports
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rs_q  <= mem[rs_addr];
      rt_q  <= mem[rt_addr];
      rs_aq <= rs_addr;
      rt_aq <= rt_addr;
    end
  end

  // Track written entries; register zero is never written
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rs_vq <= 1'b0;
      rt_vq <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rs_vq <= valid[rs_addr];
        rt_vq <= valid[rt_addr];
      end
    end
  end

  // Hold the last write for a read that raced it
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en <= 1'b0;
    end else if (wr.en) begin
      fwd_en <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_addr <= wr.addr;
      fwd_data <= wr.data;
    end
  end

  // Resolve operands: bypass, then memory, then reset value
  always_comb begin
    if (fwd_en && fwd_addr == rs_aq) begin
      rs_data = fwd_data;
    end else if (rs_vq) begin
      rs_data = rs_q;
    end else begin
      rs_data = '0;
    end
    if (fwd_en && fwd_addr == rt_aq) begin
      rt_data = fwd_data;
    end else if (rt_vq) begin
      rt_data = rt_q;
    end else begin
      rt_data = '0;
    end
  end

endmodule

FILE: sv/rte_alu.sv
// Operation decode, ALU, shifter and multiplier of the execute unit.
// Produces the result item and the Hi/Lo update. Depends on rte_pkg.
module rte_alu import rte_pkg::*; (
  input  rte_cmd_t    cmd,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] hi,
  input  logic [31:0] lo,
  input  logic        unread,
  output rte_res_t    res,
  output rte_hilo_t   hl
);

  logic               sx;
  logic signed [65:0] prod;

  // Signed or unsigned 32x32 product via 33-bit operands
  assign sx   = (cmd.function_code == FN_MULT);
  assign prod = $signed({sx & a[31], a}) * $signed({sx & b[31], b});

  always_comb begin
    logic        writes;
    logic        wz_check;
    logic [31:0] val;

    writes   = 1'b0;
    wz_check = 1'b1;
    val      = '0;
    res      = '0;
    hl       = '0;
    hl.hi    = prod[63:32];
    hl.lo    = prod[31:0];

    if (cmd.action == ACT_LOAD) begin
      writes   = 1'b1;
      wz_check = 1'b0;
      val      = cmd.load_value;
    end else begin
      unique case (cmd.function_code)
        FN_ADD: begin
          val    = a + b;
          writes = 1'b1;
          res.overflow_error = (a[31] == b[31]) && (val[31] != a[31]);
        end
        FN_ADDU: begin
          val    = a + b;
          writes = 1'b1;
        end
        FN_SUB: begin
          val    = a - b;
          writes = 1'b1;
          res.overflow_error = (a[31] != b[31]) && (val[31] != a[31]);
        end
        FN_AND: begin
          val    = a & b;
          writes = 1'b1;
        end
        FN_OR: begin
          val    = a | b;
          writes = 1'b1;
        end
        FN_XOR: begin
          val    = a ^ b;
          writes = 1'b1;
        end
        FN_NOR: begin
          val    = ~(a | b);
          writes = 1'b1;
        end
        FN_NAND: begin
          val    = ~(a & b);
          writes = 1'b1;
        end
        FN_SLT: begin
          val    = {31'd0, $signed(a) < $signed(b)};
          writes = 1'b1;
        end
        FN_SLL: begin
          val      = b << cmd.shift_amount;
          writes   = 1'b1;
          wz_check = 1'b0;
        end
        FN_SRL: begin
          val    = b >> cmd.shift_amount;
          writes = 1'b1;
        end
        FN_SRA: begin
          val    = $unsigned($signed(b) >>> cmd.shift_amount);
          writes = 1'b1;
        end
        FN_JR: begin
          res.jump_taken  = 1'b1;
          res.jump_target = a[31:2];
        end
        FN_MULT, FN_MULTU: begin
          res.hilo_overwrite_error = unread;
          hl.mult_en               = 1'b1;
        end
        FN_MFHI: begin
          val             = hi;
          writes          = 1'b1;
          hl.clear_unread = 1'b1;
        end
        FN_MFLO: begin
          val             = lo;
          writes          = 1'b1;
          hl.clear_unread = 1'b1;
        end
        default: begin
          res.unknown_function = 1'b1;
        end
      endcase
    end

    // Register zero takes no value
    if (cmd.dest_reg == REG_ZERO) begin
      val = '0;
    end

    if (writes) begin
      res.write_enable     = 1'b1;
      res.write_reg        = cmd.dest_reg;
      res.write_value      = val;
      res.write_zero_error = wz_check && (cmd.dest_reg == REG_ZERO);
    end
  end

endmodule

FILE: sv/r_type_execute_unit.sv
// Top level of the R-type execute unit: read stage, execute/commit stage
// and output register. Depends on rte_pkg, rte_regfile and rte_alu.
//
//   channel | direction | payload   | handshake
//   cmd     | in        | rte_cmd_t | cmd_valid / cmd_stall
//   res     | out       | rte_res_t | res_valid / res_stall
//
// One instruction per cycle sustained while results are not stalled; a
// command's operands are read at its transfer, and it executes and writes
// back as its result is registered in the output register.
// The register file read latency sets the stage count; a bypass register
// covers back-to-back dependent instructions.
// Reset clears the register file valid bits, Hi/Lo and the pipeline.
// A stalled result holds the output register; the command side stalls only
// when the execute stage is full and cannot advance.
module r_type_execute_unit import rte_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  rte_cmd_t cmd,
  output logic     res_valid,
  input  logic     res_stall,
  output rte_res_t res
);

  logic        s1_valid;
  rte_cmd_t    s1_cmd;
  logic        s1_adv;
  logic        cmd_xfer;
  logic        commit;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] hi;
  logic [31:0] lo;
  logic        unread;
  rte_res_t    alu_res;
  rte_hilo_t   alu_hl;
  rte_wr_t     wr;

  assign s1_adv    = !res_valid || !res_stall;
  assign cmd_stall = s1_valid && !s1_adv;
  assign cmd_xfer  = cmd_valid && !cmd_stall;
  assign commit    = s1_valid && s1_adv;

  // Write back only real registers
  assign wr.en   = commit && alu_res.write_enable && (alu_res.write_reg != REG_ZERO);
  assign wr.addr = alu_res.write_reg;
  assign wr.data = alu_res.write_value;

  rte_regfile u_rf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cmd_xfer),
    .rs_addr (cmd.source_reg),
    .rt_addr (cmd.target_reg),
    .wr      (wr),
    .rs_data (op_a),
    .rt_data (op_b)
  );

  rte_alu u_alu (
    .cmd    (s1_cmd),
    .a      (op_a),
    .b      (op_b),
    .hi     (hi),
    .lo     (lo),
    .unread (unread),
    .res    (alu_res),
    .hl     (alu_hl)
  );

  // Execute stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_xfer) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      s1_cmd <= cmd;
    end
  end

  // Update Hi/Lo and the unread flag on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      hi     <= '0;
      lo     <= '0;
      unread <= 1'b0;
    end else if (commit) begin
      if (alu_hl.mult_en) begin
        hi     <= alu_hl.hi;
        lo     <= alu_hl.lo;
        unread <= 1'b1;
      end else if (alu_hl.clear_unread) begin
        unread <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res <= alu_res;
    end
  end

endmodule

FILE: sv/rte_checker.sv
// Port-level checks for the R-type execute unit, bound to the top level.
// Depends on rte_pkg and r_type_execute_unit.
module rte_checker import rte_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     cmd_stall,
  input logic     res_valid,
  input logic     res_stall,
  input rte_res_t res
);

  // Hold a stalled result transfer
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // A result never both writes a register and jumps
  a_write_or_jump: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.write_enable && res.jump_taken))
    else $error("result writes and jumps");

  // Unknown function leaves every other flag clear
  a_unknown_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.unknown_function |->
      !res.write_enable && !res.jump_taken && !res.overflow_error &&
      !res.hilo_overwrite_error && !res.write_zero_error)
    else $error("unknown function with side effects");

  // Zero-register error only on a write to register zero with zero data
  a_zero_write: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.write_zero_error |->
      res.write_enable && res.write_reg == REG_ZERO && res.write_value == '0)
    else $error("bad register zero write report");

  // Command side stalls only while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid && res_stall)
    else $error("command stalled without output backpressure");

endmodule

bind r_type_execute_unit rte_checker u_rte_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

FILE: verif/tb_r_type_execute_unit.sv
// Self-checking testbench for r_type_execute_unit: a directed pass, then random instruction streams
// checked against an in-bench register file, Hi/Lo and multiply model.
// Depends on rte_pkg and the r_type_execute_unit RTL.
module tb_r_type_execute_unit;
  import rte_pkg::*;

  // Function code that no instruction uses
  localparam logic [5:0] FN_UNUSED = 6'h3f;
  localparam int RANDOM_CHUNKS = 4;
  localparam int CHUNK_ITEMS   = 200;
  localparam int TAIL_CYCLES   = 10;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  rte_cmd_t cmd = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  rte_res_t res;

  // Architectural copy of the unit's state
  logic [31:0] gpr [32] = '{default: '0};
  logic [31:0] hi_word = '0;
  logic [31:0] lo_word = '0;
  logic        product_pending = 1'b0;

  rte_cmd_t pending_cmds [$];
  rte_res_t expected_results [$];
  int       sent_count = 0;
  int       received_count = 0;
  int       error_count = 0;
  int       send_gap = 0;
  int       stall_left = 0;
  logic     send_idle = 1'b1;
  logic     recv_idle = 1'b1;

  r_type_execute_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Execute one instruction against the model state and return its result
  function automatic rte_res_t execute_model(input rte_cmd_t c);
    rte_res_t           r;
    logic [31:0]        a;
    logic [31:0]        b;
    logic [31:0]        v;
    logic               writes;
    logic               zero_check;
    logic signed [63:0] sprod;
    logic [63:0]        uprod;
    r          = '0;
    a          = (c.source_reg == REG_ZERO) ? 32'd0 : gpr[c.source_reg];
    b          = (c.target_reg == REG_ZERO) ? 32'd0 : gpr[c.target_reg];
    v          = '0;
    writes     = 1'b0;
    zero_check = 1'b1;
    if (c.action == ACT_LOAD) begin
      v          = c.load_value;
      writes     = 1'b1;
      zero_check = 1'b0;
    end else begin
      case (c.function_code)
        FN_ADD: begin
          v = a + b;
          writes = 1'b1;
          r.overflow_error = (a[31] == b[31]) && (v[31] != a[31]);
        end
        FN_ADDU: begin
          v = a + b;
          writes = 1'b1;
        end
        FN_SUB: begin
          v = a - b;
          writes = 1'b1;
          r.overflow_error = (a[31] != b[31]) && (v[31] != a[31]);
        end
        FN_AND:  begin v = a & b;    writes = 1'b1; end
        FN_OR:   begin v = a | b;    writes = 1'b1; end
        FN_XOR:  begin v = a ^ b;    writes = 1'b1; end
        FN_NOR:  begin v = ~(a | b); writes = 1'b1; end
        FN_NAND: begin v = ~(a & b); writes = 1'b1; end
        FN_SLT: begin
          v = {31'd0, ($signed(a) < $signed(b))};
          writes = 1'b1;
        end
        FN_SLL: begin
          v = b << c.shift_amount;
          writes = 1'b1;
          zero_check = 1'b0;
        end
        FN_SRL: begin v = b >> c.shift_amount; writes = 1'b1; end
        FN_SRA: begin v = $signed(b) >>> c.shift_amount; writes = 1'b1; end
        FN_JR: begin
          r.jump_taken  = 1'b1;
          r.jump_target = a[31:2];
        end
        FN_MULT: begin
          r.hilo_overwrite_error = product_pending;
          sprod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          hi_word = sprod[63:32];
          lo_word = sprod[31:0];
          product_pending = 1'b1;
        end
        FN_MULTU: begin
          r.hilo_overwrite_error = product_pending;
          uprod = {32'd0, a} * {32'd0, b};
          hi_word = uprod[63:32];
          lo_word = uprod[31:0];
          product_pending = 1'b1;
        end
        FN_MFHI: begin
          v = hi_word;
          writes = 1'b1;
          product_pending = 1'b0;
        end
        FN_MFLO: begin
          v = lo_word;
          writes = 1'b1;
          product_pending = 1'b0;
        end
        default: r.unknown_function = 1'b1;
      endcase
    end
    // Commit the write; register 0 keeps zero
    if (writes) begin
      if (c.dest_reg == REG_ZERO) v = '0;
      else gpr[c.dest_reg] = v;
      r.write_enable     = 1'b1;
      r.write_reg        = c.dest_reg;
      r.write_value      = v;
      r.write_zero_error = zero_check && (c.dest_reg == REG_ZERO);
    end
    return r;
  endfunction

  function automatic rte_cmd_t make_cmd(input logic act, input logic [5:0] fn,
                                        input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sh,
                                        input logic [31:0] lv);
    rte_cmd_t c;
    c.action        = act;
    c.function_code = fn;
    c.source_reg    = rs;
    c.target_reg    = rt;
    c.dest_reg      = rd;
    c.shift_amount  = sh;
    c.load_value    = lv;
    return c;
  endfunction

  // Mostly a few hot registers to build dependency chains
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return 32'($urandom_range(0, 15));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic rte_cmd_t random_cmd();
    rte_cmd_t   c;
    logic [5:0] fn;
    case ($urandom_range(0, 16))
      0:  fn = FN_SLL;
      1:  fn = FN_SRL;
      2:  fn = FN_SRA;
      3:  fn = FN_JR;
      4:  fn = FN_MFHI;
      5:  fn = FN_MFLO;
      6:  fn = FN_MULT;
      7:  fn = FN_MULTU;
      8:  fn = FN_ADD;
      9:  fn = FN_ADDU;
      10: fn = FN_SUB;
      11: fn = FN_AND;
      12: fn = FN_OR;
      13: fn = FN_XOR;
      14: fn = FN_NOR;
      15: fn = FN_NAND;
      default: fn = FN_SLT;
    endcase
    if ($urandom_range(0, 9) == 0) fn = 6'($urandom_range(0, 63));
    c = make_cmd(ACT_EXEC, fn, pick_reg(), pick_reg(), pick_reg(),
                 5'($urandom_range(0, 31)), 32'($urandom));
    // Roughly a quarter are register loads
    if ($urandom_range(0, 3) == 0) begin
      c.action     = ACT_LOAD;
      c.load_value = pick_value();
    end
    return c;
  endfunction

  // Driver: present queued commands, hold a stalled transfer, insert gaps
  always @(posedge clk) begin : drive
    logic     next_valid;
    rte_cmd_t next_cmd;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      next_valid = cmd_valid;
      next_cmd   = cmd;
      if (cmd_valid && !cmd_stall) begin
        expected_results.push_back(execute_model(cmd));
        sent_count++;
        next_valid = 1'b0;
        if (sent_count % 64 == 0) send_idle = ($urandom_range(0, 2) != 0);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          next_cmd   = pending_cmds.pop_front();
          next_valid = 1'b1;
          send_gap   = send_idle ? $urandom_range(0, 4) : 0;
        end
      end
      cmd_valid <= next_valid;
      cmd       <= next_cmd;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin : watch
    rte_res_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        received_count++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, res);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("write_enable", 32'(want.write_enable), 32'(res.write_enable));
          check_field("write_reg", 32'(want.write_reg), 32'(res.write_reg));
          check_field("write_value", want.write_value, res.write_value);
          check_field("jump_taken", 32'(want.jump_taken), 32'(res.jump_taken));
          check_field("jump_target", 32'(want.jump_target), 32'(res.jump_target));
          check_field("write_zero_error", 32'(want.write_zero_error),
                      32'(res.write_zero_error));
          check_field("overflow_error", 32'(want.overflow_error), 32'(res.overflow_error));
          check_field("hilo_overwrite_error", 32'(want.hilo_overwrite_error),
                      32'(res.hilo_overwrite_error));
          check_field("unknown_function", 32'(want.unknown_function),
                      32'(res.unknown_function));
        end
        if (received_count % 50 == 0) recv_idle = ($urandom_range(0, 2) != 0);
        stall_left = recv_idle ? $urandom_range(0, 4) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      res_stall <= (stall_left > 0);
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Operand extremes
    pending_cmds.push_back(make_cmd(ACT_LOAD, FN_SLL, 0, 0, 1, 0, 32'h7fff_ffff));
    pending_cmds.push_back(make_cmd(ACT_LOAD, FN_SLL, 0, 0, 2, 0, 32'h8000_0000));
    pending_cmds.push_back(make_cmd(ACT_LOAD, FN_SLL, 0, 0, 3, 0, 32'hffff_ffff));
    pending_cmds.push_back(make_cmd(ACT_LOAD, FN_SLL, 0, 0, 4, 0, 32'h0000_0001));
    // Load into register 0 must leave it zero without an error
    pending_cmds.push_back(make_cmd(ACT_LOAD, FN_SLL, 0, 0, 0, 0, 32'hdead_beef));
    // Overflowing add and sub still write the wrapped value
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_ADD, 1, 4, 5, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_SUB, 2, 4, 6, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_ADDU, 3, 4, 7, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_AND, 1, 3, 8, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_OR, 2, 4, 9, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_XOR, 3, 1, 10, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_NOR, 0, 0, 11, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_NAND, 3, 3, 12, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_SLT, 2, 1, 13, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_SLT, 1, 2, 14, 0, 0));
    // Of the executed instructions, sll is the one that writes register 0 with no error
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_SLL, 0, 3, 0, 31, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_SRL, 0, 3, 15, 31, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_SRA, 0, 2, 16, 31, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_SRA, 0, 2, 17, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_JR, 3, 0, 0, 0, 0));
    // Second multiply overwrites an unread product
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_MULT, 2, 3, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_MULTU, 3, 3, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_MFHI, 0, 0, 18, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_MFLO, 0, 0, 19, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_UNUSED, 3, 3, 0, 0, 0));
    pending_cmds.push_back(make_cmd(ACT_EXEC, FN_ADD, 1, 1, 0, 0, 0));

    // Random chunks; drain the unit completely before each one
    for (int k = 0; k < RANDOM_CHUNKS; k++) begin
      while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0)
        @(posedge clk);
      for (int i = 0; i < CHUNK_ITEMS; i++) pending_cmds.push_back(random_cmd());
    end

    while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** r_type_execute_unit: PASSED **");
    end else begin
      $display("** r_type_execute_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("** r_type_execute_unit: FAILED **");
    $finish;
  end

endmodule
